// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; box_iou_unit.sv includes them.
// With SYNTHESIS defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent true at a clock edge implies the consequent at the same edge.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif

`endif

// File: hw/rtl/biou_pkg.sv
package biou_pkg;

    // Default geometry and ratio precision
    localparam int COORD_BITS_DEF      = 16;
    localparam int RATIO_FRAC_BITS_DEF = 16;

    // Minimum-union threshold register
    localparam int               MIN_UNION_BITS = 16;
    localparam logic [15:0]      MIN_UNION_RST  = 16'd1;

endpackage

// File: hw/rtl/biou_geom.sv
// Box geometry: overlap spans and edge differences, then the three area products.
module biou_geom #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [COORD_BITS-1:0]         a_left,
    input  logic [COORD_BITS-1:0]         a_top,
    input  logic [COORD_BITS-1:0]         a_right,
    input  logic [COORD_BITS-1:0]         a_bottom,
    input  logic [COORD_BITS-1:0]         b_left,
    input  logic [COORD_BITS-1:0]         b_top,
    input  logic [COORD_BITS-1:0]         b_right,
    input  logic [COORD_BITS-1:0]         b_bottom,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*COORD_BITS-1:0]       inter,
    output logic signed [2*COORD_BITS+1:0] area_a,
    output logic signed [2*COORD_BITS+1:0] area_b
);
    import biou_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int AW = 2*COORD_BITS + 2;

    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 s1_ready;
    logic                 s2_ready;

    logic [C-1:0]         iw_reg, iw_next;
    logic [C-1:0]         ih_reg, ih_next;
    logic signed [C:0]    wa_reg, wa_next;
    logic signed [C:0]    ha_reg, ha_next;
    logic signed [C:0]    wb_reg, wb_next;
    logic signed [C:0]    hb_reg, hb_next;

    logic [2*C-1:0]       inter_reg, inter_next;
    logic signed [AW-1:0] area_a_reg, area_a_next;
    logic signed [AW-1:0] area_b_reg, area_b_next;

    logic [C-1:0]         x_lo, x_hi, y_lo, y_hi;

    // Stall chain: a stage takes new data when empty or when it drains
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: overlap spans clamped at zero, signed box extents
    always_comb
    begin
        x_lo    = (a_left  > b_left)   ? a_left   : b_left;
        x_hi    = (a_right < b_right)  ? a_right  : b_right;
        y_lo    = (a_top   > b_top)    ? a_top    : b_top;
        y_hi    = (a_bottom < b_bottom) ? a_bottom : b_bottom;
        iw_next = (x_hi > x_lo) ? (x_hi - x_lo) : '0;
        ih_next = (y_hi > y_lo) ? (y_hi - y_lo) : '0;
        wa_next = $signed({1'b0, a_right})  - $signed({1'b0, a_left});
        ha_next = $signed({1'b0, a_bottom}) - $signed({1'b0, a_top});
        wb_next = $signed({1'b0, b_right})  - $signed({1'b0, b_left});
        hb_next = $signed({1'b0, b_bottom}) - $signed({1'b0, b_top});
    end

    // Stage 2: intersection and box areas
    always_comb
    begin
        inter_next  = (2*C)'(iw_reg) * (2*C)'(ih_reg);
        area_a_next = AW'(wa_reg) * AW'(ha_reg);
        area_b_next = AW'(wb_reg) * AW'(hb_reg);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            iw_reg <= iw_next;
            ih_reg <= ih_next;
            wa_reg <= wa_next;
            ha_reg <= ha_next;
            wb_reg <= wb_next;
            hb_reg <= hb_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            inter_reg  <= inter_next;
            area_a_reg <= area_a_next;
            area_b_reg <= area_b_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign inter     = inter_reg;
    assign area_a    = area_a_reg;
    assign area_b    = area_b_reg;

endmodule

// File: hw/rtl/biou_union.sv
// Union area, threshold guard and saturation check; prepares the divider operands.
module biou_union #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2*COORD_BITS-1:0]            inter,
    input  logic signed [2*COORD_BITS+1:0]     area_a,
    input  logic signed [2*COORD_BITS+1:0]     area_b,
    input  logic [biou_pkg::MIN_UNION_BITS-1:0] min_union,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2*COORD_BITS:0]              num,
    output logic [2*COORD_BITS:0]              den,
    output logic                               force_one,
    output logic                               guarded
);
    import biou_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int SW = 2*COORD_BITS + 3;
    localparam int UW = 2*COORD_BITS + 1;

    logic                 s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic                 s3_ready, s4_ready, s5_ready;

    logic signed [SW-1:0] sum_reg, sum_next;
    logic [2*C-1:0]       inter3_reg;
    logic signed [SW-1:0] uni_reg, uni_next;
    logic [2*C-1:0]       inter4_reg;

    logic [UW-1:0]        num_reg, num_next;
    logic [UW-1:0]        den_reg;
    logic                 force_reg, force_next;
    logic                 guard_reg, guard_next;
    logic                 sat;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    // Stage 3: sum of box areas
    assign sum_next = SW'(area_a) + SW'(area_b);

    // Stage 4: remove the doubly counted intersection
    assign uni_next = sum_reg - $signed({{(SW-2*C){1'b0}}, inter3_reg});

    // Stage 5: small or non-positive union forces one; a ratio of one or more saturates
    always_comb
    begin
        guard_next = (uni_reg <= 0)
                  || (uni_reg < $signed({{(SW-MIN_UNION_BITS){1'b0}}, min_union}));
        sat        = ({1'b0, inter4_reg} >= uni_reg[UW-1:0]);
        force_next = guard_next || sat;
        num_next   = force_next ? '0 : {1'b0, inter4_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            sum_reg    <= sum_next;
            inter3_reg <= inter;
        end
        if (s4_ready && s3_valid_reg)
        begin
            uni_reg    <= uni_next;
            inter4_reg <= inter3_reg;
        end
        if (s5_ready && s4_valid_reg)
        begin
            num_reg   <= num_next;
            den_reg   <= uni_reg[UW-1:0];
            force_reg <= force_next;
            guard_reg <= guard_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign force_one = force_reg;
    assign guarded   = guard_reg;

endmodule

// File: hw/rtl/biou_divider.sv
// Pipelined restoring divider, one quotient bit per stage, plus the output register.
module biou_divider #(
    parameter int COORD_BITS      = biou_pkg::COORD_BITS_DEF,
    parameter int RATIO_FRAC_BITS = biou_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2*COORD_BITS:0]      num,
    input  logic [2*COORD_BITS:0]      den,
    input  logic                       force_one,
    input  logic                       guarded,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [RATIO_FRAC_BITS:0]   ratio,
    output logic                       union_guarded
);
    import biou_pkg::*;

    localparam int UW = 2*COORD_BITS + 1;
    localparam int F  = RATIO_FRAC_BITS;
    localparam logic [F:0] RATIO_ONE = {1'b1, {F{1'b0}}};

    // Step stage registers
    logic [F-1:0]  v_reg;
    logic [UW-1:0] rem_reg [F];
    logic [UW-1:0] den_reg [F];
    logic [F-1:0]  q_reg   [F];
    logic [F-1:0]  one_reg;
    logic [F-1:0]  grd_reg;

    // Output stage
    logic          out_v_reg;
    logic [F:0]    ratio_reg;
    logic          guard_out_reg;

    // Stage inputs and step results
    logic [F-1:0]  src_v;
    logic [UW-1:0] src_rem [F];
    logic [UW-1:0] src_den [F];
    logic [F-1:0]  src_q   [F];
    logic [F-1:0]  src_one;
    logic [F-1:0]  src_grd;
    logic [UW:0]   trial   [F];
    logic [F-1:0]  ge;
    logic [UW-1:0] rem_next [F];
    logic [F-1:0]  q_next   [F];
    logic [F:0]    rdy;

    // Stall chain from the output backwards
    always_comb
    begin
        rdy[F] = !out_v_reg || out_ready;
        for (int k = F - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    // Each stage sees the previous stage's registers
    always_comb
    begin
        src_v[0]   = in_valid;
        src_rem[0] = num;
        src_den[0] = den;
        src_q[0]   = '0;
        src_one[0] = force_one;
        src_grd[0] = guarded;
        for (int k = 1; k < F; k++)
        begin
            src_v[k]   = v_reg[k-1];
            src_rem[k] = rem_reg[k-1];
            src_den[k] = den_reg[k-1];
            src_q[k]   = q_reg[k-1];
            src_one[k] = one_reg[k-1];
            src_grd[k] = grd_reg[k-1];
        end
    end

    // One restoring step per stage: remainder stays below the divisor
    always_comb
    begin
        for (int k = 0; k < F; k++)
        begin
            trial[k]    = {src_rem[k], 1'b0};
            ge[k]       = (trial[k] >= {1'b0, src_den[k]});
            rem_next[k] = ge[k] ? UW'(trial[k] - {1'b0, src_den[k]}) : trial[k][UW-1:0];
            q_next[k]   = {src_q[k][F-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < F; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= src_v[k];
                end
            end
            if (rdy[F])
            begin
                out_v_reg <= v_reg[F-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < F; k++)
        begin
            if (rdy[k] && src_v[k])
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= src_den[k];
                q_reg[k]   <= q_next[k];
                one_reg[k] <= src_one[k];
                grd_reg[k] <= src_grd[k];
            end
        end
        if (rdy[F] && v_reg[F-1])
        begin
            ratio_reg     <= one_reg[F-1] ? RATIO_ONE : {1'b0, q_reg[F-1]};
            guard_out_reg <= grd_reg[F-1];
        end
    end

    assign out_valid     = out_v_reg;
    assign ratio         = ratio_reg;
    assign union_guarded = guard_out_reg;

endmodule

// File: hw/rtl/box_iou_unit.sv
// Intersection over union of two boxes per item.
// Pipeline: geometry stages, union stages, divider step stages, then the output register.
// Throughput: one item per cycle unless stalled; one divider stage per quotient bit.
// Stalls back up stage by stage; empty stages keep accepting while the output waits.
// Reset (rst_n, async, active low) empties the pipeline and sets min_union to 1.
`include "assert_macros.svh"

module box_iou_unit #(
    parameter int COORD_BITS      = biou_pkg::COORD_BITS_DEF,
    parameter int RATIO_FRAC_BITS = biou_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Threshold register write
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [biou_pkg::MIN_UNION_BITS-1:0]    cfg_data,
    // Input boxes
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
    input  logic [8*COORD_BITS-1:0]                s_axis_tdata,
    // Result
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // overlap_ratio, zero padding
    output logic [((RATIO_FRAC_BITS+8)/8)*8-1:0]   m_axis_tdata,
    // union_guarded
    output logic                                   m_axis_tuser
);
    import biou_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = RATIO_FRAC_BITS;
    localparam int OUT_W = ((RATIO_FRAC_BITS + 8) / 8) * 8;
    localparam logic [F:0] RATIO_ONE = {1'b1, {F{1'b0}}};

    logic [MIN_UNION_BITS-1:0] min_union_reg;

    logic                      geo_valid, geo_ready;
    logic [2*C-1:0]            inter;
    logic signed [2*C+1:0]     area_a, area_b;

    logic                      uni_valid, uni_ready;
    logic [2*C:0]              num, den;
    logic                      force_one, guarded;

    logic [F:0]                ratio;

    // Threshold register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_union_reg <= MIN_UNION_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_union_reg <= cfg_data;
        end
    end

    biou_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .a_left    (s_axis_tdata[0*C +: C]),
        .a_top     (s_axis_tdata[1*C +: C]),
        .a_right   (s_axis_tdata[2*C +: C]),
        .a_bottom  (s_axis_tdata[3*C +: C]),
        .b_left    (s_axis_tdata[4*C +: C]),
        .b_top     (s_axis_tdata[5*C +: C]),
        .b_right   (s_axis_tdata[6*C +: C]),
        .b_bottom  (s_axis_tdata[7*C +: C]),
        .out_valid (geo_valid),
        .out_ready (geo_ready),
        .inter     (inter),
        .area_a    (area_a),
        .area_b    (area_b)
    );

    biou_union #(
        .COORD_BITS (COORD_BITS)
    ) u_union (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geo_valid),
        .in_ready  (geo_ready),
        .inter     (inter),
        .area_a    (area_a),
        .area_b    (area_b),
        .min_union (min_union_reg),
        .out_valid (uni_valid),
        .out_ready (uni_ready),
        .num       (num),
        .den       (den),
        .force_one (force_one),
        .guarded   (guarded)
    );

    biou_divider #(
        .COORD_BITS      (COORD_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_divider (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (uni_valid),
        .in_ready      (uni_ready),
        .num           (num),
        .den           (den),
        .force_one     (force_one),
        .guarded       (guarded),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .ratio         (ratio),
        .union_guarded (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'(ratio);

    // Checks
    `ASSERT_IMP(a_guard_is_one, clk, rst_n, m_axis_tvalid && m_axis_tuser, ratio == RATIO_ONE)
    `ASSERT_IMP(a_ratio_le_one, clk, rst_n, m_axis_tvalid, ratio <= RATIO_ONE)
    `ASSERT_IMP(a_stall_from_out, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule
